[design/bsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int BUFFER_SIZE = 4096;
  localparam int ROOM_CAP    = ((BUFFER_SIZE - 1) < 16383) ? (BUFFER_SIZE - 1) : 16383;
  localparam int ROOM_W      = $clog2(ROOM_CAP + 1);
  localparam int BURST_MAX   = 8;

  // Configuration register indexes
  localparam logic [2:0] REG_OLD_PATTERN = 3'd0;
  localparam logic [2:0] REG_OLD_LENGTH  = 3'd1;
  localparam logic [2:0] REG_NEW_PATTERN = 3'd2;
  localparam logic [2:0] REG_NEW_LENGTH  = 3'd3;
  localparam logic [2:0] REG_SPARE_ROOM  = 3'd4;

  typedef struct packed {
    logic [63:0] old_pattern;
    logic [3:0]  old_length;
    logic [63:0] new_pattern;
    logic [3:0]  new_length;
    logic [11:0] spare_room;
  } cfg_t;

  // One classified input item: the bytes it releases, lowest byte first.
  typedef struct packed {
    logic [8*BURST_MAX-1:0] bytes;
    logic [3:0]             cnt;
    logic                   last;
    logic                   gave_up;
  } burst_t;

endpackage

`default_nettype wire

[design/bsr_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bsr_pkg::cfg_t   cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_text_byte,
  input  wire logic            in_last_byte,
  output logic                 push,
  output bsr_pkg::burst_t      push_data,
  input  wire logic            push_ready
);
  import bsr_pkg::*;

  logic [7:0]        win_r   [PATTERN_MAX];
  logic [7:0]        win_nxt [PATTERN_MAX];
  logic [7:0]        win_ins [PATTERN_MAX];
  logic [7:0]        win_sh  [PATTERN_MAX];
  logic [3:0]        pend_r, pend_nxt;
  logic [ROOM_W-1:0] room_r, room_nxt;
  logic              stop_r, stop_nxt;
  logic              start_r;
  logic [3:0]        act_old_r, act_new_r;

  logic [3:0]        eff_old, eff_new, eff_pend, pend_inc;
  logic [ROOM_W-1:0] eff_room, room_ld;
  logic              eff_stop, match, overflow, accept;
  logic [3:0]        sat_old, sat_new;
  logic [ROOM_W:0]   grow, shrink, room_sum;
  logic [8*BURST_MAX-1:0] win_flat;
  burst_t            burst;

  assign accept   = in_valid && in_ready;
  assign in_ready = push_ready;

  assign sat_old = (cfg.old_length > 4'(PATTERN_MAX)) ? 4'(PATTERN_MAX) : cfg.old_length;
  assign sat_new = (cfg.new_length > 4'(BURST_MAX)) ? 4'(BURST_MAX) : cfg.new_length;
  assign room_ld = (32'(cfg.spare_room) > ROOM_CAP) ? ROOM_W'(ROOM_CAP)
                                                     : ROOM_W'(cfg.spare_room);

  always_comb begin
    eff_old  = start_r ? sat_old : act_old_r;
    eff_new  = start_r ? sat_new : act_new_r;
    eff_room = start_r ? room_ld : room_r;
    eff_stop = start_r ? 1'b0 : stop_r;
    eff_pend = start_r ? 4'd0 : pend_r;
    if (eff_pend >= eff_old) begin
      eff_pend = 4'd0;
    end
    pend_inc = eff_pend + 4'd1;

    win_flat = '0;
    match    = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      win_ins[i] = (eff_pend == 4'(i)) ? in_text_byte : win_r[i];
      win_flat[8*i +: 8] = win_ins[i];
      if ((4'(i) < eff_old) && (win_ins[i] != cfg.old_pattern[8*i +: 8])) begin
        match = 1'b0;
      end
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      win_sh[i] = (i < PATTERN_MAX - 1) ? win_ins[(i + 1) % PATTERN_MAX] : win_ins[i];
    end

    grow     = (eff_new > eff_old) ? (ROOM_W + 1)'(eff_new - eff_old) : '0;
    shrink   = (eff_old > eff_new) ? (ROOM_W + 1)'(eff_old - eff_new) : '0;
    overflow = grow > {1'b0, eff_room};
    room_sum = {1'b0, eff_room} + shrink - grow;
  end

  // Classify the item: what it releases and how the window moves.
  always_comb begin
    win_nxt       = win_r;
    pend_nxt      = eff_pend;
    room_nxt      = eff_room;
    stop_nxt      = eff_stop;
    burst.bytes   = '0;
    burst.cnt     = 4'd0;
    if (eff_stop || (eff_old == 4'd0)) begin
      burst.bytes[7:0] = in_text_byte;
      burst.cnt        = 4'd1;
    end else begin
      win_nxt  = win_ins;
      pend_nxt = pend_inc;
      if (pend_inc == eff_old) begin
        if (match && overflow) begin
          stop_nxt    = 1'b1;
          burst.bytes = win_flat;
          burst.cnt   = eff_old;
          pend_nxt    = 4'd0;
        end else if (match) begin
          burst.bytes = cfg.new_pattern;
          burst.cnt   = eff_new;
          pend_nxt    = 4'd0;
          room_nxt    = (room_sum > (ROOM_W + 1)'(ROOM_CAP)) ? ROOM_W'(ROOM_CAP)
                                                             : room_sum[ROOM_W-1:0];
        end else begin
          // Release the oldest byte; at the string end flush the rest too.
          burst.bytes = win_flat;
          burst.cnt   = in_last_byte ? eff_old : 4'd1;
          win_nxt     = win_sh;
          pend_nxt    = eff_old - 4'd1;
        end
      end else if (in_last_byte) begin
        burst.bytes = win_flat;
        burst.cnt   = pend_inc;
      end
    end
    burst.last    = in_last_byte;
    burst.gave_up = stop_nxt;
  end

  assign push      = accept && ((burst.cnt != 4'd0) || in_last_byte);
  assign push_data = burst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= 1'b1;
      stop_r    <= 1'b0;
      pend_r    <= 4'd0;
      room_r    <= '0;
      act_old_r <= 4'd0;
      act_new_r <= 4'd0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
        win_r[i] <= 8'd0;
      end
    end else if (accept) begin
      start_r   <= in_last_byte;
      stop_r    <= stop_nxt;
      pend_r    <= pend_nxt;
      room_r    <= room_nxt;
      act_old_r <= eff_old;
      act_new_r <= eff_new;
      win_r     <= win_nxt;
    end
  end

endmodule

`default_nettype wire

[design/bsr_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsr_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire bsr_pkg::burst_t push_data,
  output logic                 push_ready,
  input  wire logic            pop,
  output logic                 pop_valid,
  output bsr_pkg::burst_t      pop_data
);
  import bsr_pkg::*;

  burst_t     mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

[design/bsr_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsr_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            pop_valid,
  input  wire bsr_pkg::burst_t pop_data,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_has_byte,
  output logic                 out_run_end,
  output logic                 out_string_end,
  output logic                 out_gave_up
);
  import bsr_pkg::*;

  logic                   busy_r, busy_nxt;
  logic [8*BURST_MAX-1:0] bytes_r, bytes_nxt;
  logic [3:0]             rem_r, rem_nxt;
  logic                   last_r, last_nxt, gu_r, gu_nxt;
  logic                   slot_free, emit;
  logic                   ov_r;
  logic [7:0]             ob_r, ob_nxt;
  logic                   oh_r, oh_nxt, ore_r, ore_nxt, ose_r, ose_nxt, og_r, og_nxt;

  assign slot_free = !ov_r || out_ready;
  assign pop       = slot_free && !busy_r && pop_valid;
  assign emit      = slot_free && (busy_r || pop_valid);

  always_comb begin
    busy_nxt  = busy_r;
    bytes_nxt = bytes_r;
    rem_nxt   = rem_r;
    last_nxt  = last_r;
    gu_nxt    = gu_r;
    ob_nxt    = ob_r;
    oh_nxt    = oh_r;
    ore_nxt   = ore_r;
    ose_nxt   = ose_r;
    og_nxt    = og_r;
    if (slot_free && busy_r) begin
      ob_nxt    = bytes_r[7:0];
      oh_nxt    = 1'b1;
      ore_nxt   = (rem_r == 4'd1);
      ose_nxt   = (rem_r == 4'd1) && last_r;
      og_nxt    = gu_r;
      bytes_nxt = bytes_r >> 8;
      rem_nxt   = rem_r - 4'd1;
      busy_nxt  = (rem_r != 4'd1);
    end else if (pop) begin
      og_nxt = pop_data.gave_up;
      if (pop_data.cnt == 4'd0) begin
        ob_nxt  = 8'd0;
        oh_nxt  = 1'b0;
        ore_nxt = 1'b1;
        ose_nxt = pop_data.last;
      end else begin
        ob_nxt    = pop_data.bytes[7:0];
        oh_nxt    = 1'b1;
        ore_nxt   = (pop_data.cnt == 4'd1);
        ose_nxt   = (pop_data.cnt == 4'd1) && pop_data.last;
        bytes_nxt = pop_data.bytes >> 8;
        rem_nxt   = pop_data.cnt - 4'd1;
        last_nxt  = pop_data.last;
        gu_nxt    = pop_data.gave_up;
        busy_nxt  = (pop_data.cnt != 4'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    rem_r   <= rem_nxt;
    last_r  <= last_nxt;
    gu_r    <= gu_nxt;
    ob_r    <= ob_nxt;
    oh_r    <= oh_nxt;
    ore_r   <= ore_nxt;
    ose_r   <= ose_nxt;
    og_r    <= og_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (slot_free) begin
        ov_r <= emit;
      end
    end
  end

  assign out_valid      = ov_r;
  assign out_byte       = ob_r;
  assign out_has_byte   = oh_r;
  assign out_run_end    = ore_r;
  assign out_string_end = ose_r;
  assign out_gave_up    = og_r;

endmodule

`default_nettype wire

[design/bounded_substring_replace_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Bounded substring replace: streams a string one byte per transfer and
// returns it with each leftmost, non-overlapping occurrence of the old
// pattern replaced by the new pattern, as long as the spare-room budget holds.
// Input channel: in_valid/in_ready carry in_text_byte and in_last_byte.
// Output channel: out_valid/out_ready carry one byte per transfer with its
// flags; a string whose last byte releases nothing ends in a marker transfer
// with out_has_byte low. out_run_end marks the last result of an input byte,
// out_string_end the last result of the string.
// Configuration: cfg_we writes cfg_wdata into register cfg_index; write only
// while the block is idle. Lengths and spare room are sampled at string start.
// Path: the first result of a byte is written into the queue at its input
// transfer, then into the output register, from which it is transferred.
// Throughput: one input byte per cycle while each byte releases at most one
// result and the receiver keeps up; the output stage gives one result per
// cycle while out_ready is high, so a replacement or flush of k bytes holds
// the back end until all k are out; the two-entry queue backs up into in_ready.
// Reset (synchronous, rst_n low) restores the register defaults, empties the
// queue and the output stage, and arms the string-start sampling.
// A stalled receiver holds the output register; the queue absorbs up to two
// more items before in_ready drops.
module bounded_substring_replace_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_has_byte,
  output logic             out_run_end,
  output logic             out_string_end,
  output logic             out_gave_up
);
  import bsr_pkg::*;

  cfg_t   cfg_r;
  logic   push, push_ready, pop, pop_valid;
  burst_t push_data, pop_data;

  // Configuration registers; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.old_pattern <= 64'd0;
      cfg_r.old_length  <= 4'd1;
      cfg_r.new_pattern <= 64'd0;
      cfg_r.new_length  <= 4'd0;
      cfg_r.spare_room  <= 12'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OLD_PATTERN: cfg_r.old_pattern <= cfg_wdata;
        REG_OLD_LENGTH:  cfg_r.old_length  <= cfg_wdata[3:0];
        REG_NEW_PATTERN: cfg_r.new_pattern <= cfg_wdata;
        REG_NEW_LENGTH:  cfg_r.new_length  <= cfg_wdata[3:0];
        REG_SPARE_ROOM:  cfg_r.spare_room  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Front: match window and budget, one byte per cycle while the queue has room.
  bsr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .in_last_byte (in_last_byte),
    .push         (push),
    .push_data    (push_data),
    .push_ready   (push_ready)
  );

  // Decouple classification from result expansion.
  bsr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  // Back: expand each burst into result transfers.
  bsr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_data       (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_has_byte   (out_has_byte),
    .out_run_end    (out_run_end),
    .out_string_end (out_string_end),
    .out_gave_up    (out_gave_up)
  );

endmodule

`default_nettype wire

[tb/bounded_substring_replace_top_test.sv]
`timescale 1ns / 1ps

module bounded_substring_replace_top_test;
  import bsr_pkg::*;

  localparam int STUCK_LIMIT = 3000;   // cycles with work pending and no transfer
  localparam int SETTLE_CYCLES = 8;    // hold-off before a register write
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } text_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       run_end;
    logic       str_end;
    logic       gave_up;
  } out_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_OLD_PATTERN;
  logic [63:0] cfg_wdata = 64'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_text_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_has_byte;
  logic        out_run_end;
  logic        out_string_end;
  logic        out_gave_up;

  bounded_substring_replace_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_byte  (in_text_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_has_byte  (out_has_byte),
    .out_run_end   (out_run_end),
    .out_string_end(out_string_end),
    .out_gave_up   (out_gave_up)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting to be driven, and results the predictor says must come out.
  text_item_t feed_q[$];
  out_item_t  due_q[$];
  out_item_t  step_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic in_taken = 1'b0;
  int stuck_cycles = 0;
  int err_count = 0;

  // Run statistics for the closing summary.
  int n_bytes_in = 0;
  int n_results = 0;
  int n_strings = 0;
  int n_swaps = 0;
  int n_runouts = 0;

  // Shadow copy of the configuration registers (reset values).
  logic [63:0] m_old_pat = 64'd0;
  logic [3:0]  m_old_len = 4'd1;
  logic [63:0] m_new_pat = 64'd0;
  logic [3:0]  m_new_len = 4'd0;
  logic [11:0] m_spare = 12'd0;

  // Predictor state: pending window, budget and per-string latched lengths.
  logic [7:0] win [0:PATTERN_MAX-1] = '{default: 8'd0};
  int   win_cnt = 0;
  int   room_left = 0;
  logic stopped = 1'b0;
  logic at_start = 1'b1;
  int   act_old = 0;
  int   act_new = 0;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  function automatic void put_byte(input logic [7:0] d, input logic has);
    out_item_t r;
    if (step_q.size() < BURST_MAX) begin
      r = '{data: d, has: has, run_end: 1'b0, str_end: 1'b0, gave_up: 1'b0};
      step_q.push_back(r);
    end
  endfunction

  function automatic void flush_pending();
    for (int i = 0; i < win_cnt && i < PATTERN_MAX; i++)
      put_byte(win[i], 1'b1);
    win_cnt = 0;
  endfunction

  // Work out the results of one accepted text byte and queue them.
  task automatic model_replace(input logic [7:0] b, input logic last);
    logic hit;
    out_item_t r;
    step_q.delete();
    if (at_start) begin
      act_old = (m_old_len > PATTERN_MAX) ? PATTERN_MAX : m_old_len;
      act_new = (m_new_len > 8) ? 8 : m_new_len;
      room_left = (m_spare > ROOM_CAP) ? ROOM_CAP : m_spare;
      stopped = 1'b0;
      win_cnt = 0;
      at_start = 1'b0;
    end
    if (stopped || act_old == 0) begin
      put_byte(b, 1'b1);
    end else begin
      if (win_cnt >= act_old || win_cnt >= PATTERN_MAX)
        win_cnt = 0;
      win[win_cnt] = b;
      win_cnt++;
      if (win_cnt == act_old) begin
        hit = 1'b1;
        for (int i = 0; i < act_old; i++)
          if (win[i] != m_old_pat[8*i +: 8])
            hit = 1'b0;
        if (hit) begin
          if (act_new > act_old && act_new - act_old > room_left) begin
            // Out of room: stop replacing, release the matched bytes as they are.
            stopped = 1'b1;
            n_runouts++;
            flush_pending();
          end else begin
            for (int i = 0; i < act_new; i++)
              put_byte(m_new_pat[8*i +: 8], 1'b1);
            if (act_new >= act_old) begin
              room_left -= act_new - act_old;
            end else begin
              room_left += act_old - act_new;
              if (room_left > ROOM_CAP)
                room_left = ROOM_CAP;
            end
            win_cnt = 0;
            n_swaps++;
          end
        end else begin
          // No match: release the oldest byte and slide the window.
          put_byte(win[0], 1'b1);
          for (int i = 0; i < PATTERN_MAX - 1; i++)
            win[i] = win[i+1];
          win_cnt--;
        end
      end
    end
    if (last) begin
      flush_pending();
      if (step_q.size() == 0)
        put_byte(8'd0, 1'b0);
      at_start = 1'b1;
      n_strings++;
    end
    for (int k = 0; k < step_q.size(); k++) begin
      r = step_q[k];
      r.gave_up = stopped;
      r.run_end = (k == step_q.size() - 1);
      r.str_end = (k == step_q.size() - 1) && last;
      due_q.push_back(r);
    end
  endtask

  // Driver: change inputs on the falling edge; hold the payload until the transfer.
  always @(negedge clk) begin : drive_inputs
    text_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = feed_q.pop_front();
        in_valid <= 1'b1;
        in_text_byte <= nxt.text;
        in_last_byte <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: on each rising edge predict accepted bytes and check delivered results.
  always @(posedge clk) begin : watch_outputs
    out_item_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        n_bytes_in++;
        model_replace(in_text_byte, in_last_byte);
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (due_q.size() == 0) begin
          report_mismatch($sformatf("result %02h arrived with nothing expected", out_byte));
        end else begin
          want = due_q.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("result %0d out_byte %02h, want %02h",
                                      n_results, out_byte, want.data));
          if (out_has_byte !== want.has)
            report_mismatch($sformatf("result %0d out_has_byte %b, want %b",
                                      n_results, out_has_byte, want.has));
          if (out_run_end !== want.run_end)
            report_mismatch($sformatf("result %0d out_run_end %b, want %b",
                                      n_results, out_run_end, want.run_end));
          if (out_string_end !== want.str_end)
            report_mismatch($sformatf("result %0d out_string_end %b, want %b",
                                      n_results, out_string_end, want.str_end));
          if (out_gave_up !== want.gave_up)
            report_mismatch($sformatf("result %0d out_gave_up %b, want %b",
                                      n_results, out_gave_up, want.gave_up));
        end
      end
    end
  end

  // Watchdog: count cycles where work is pending but neither channel moves.
  always @(posedge clk) begin
    if (rst_n && (feed_q.size() != 0 || in_valid || due_q.size() != 0)
        && !(in_valid && in_ready) && !(out_valid && out_ready)) begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
        $display("bounded_substring_replace_top_test: errors");
        $finish;
      end
    end else begin
      stuck_cycles = 0;
    end
  end

  // Block until every byte is in and every result is out, then let the pipe settle.
  task automatic wait_quiet();
    while (feed_q.size() != 0 || in_valid || due_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register and mirror it into the shadow copy.
  task automatic set_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OLD_PATTERN: m_old_pat = val;
      REG_OLD_LENGTH:  m_old_len = val[3:0];
      REG_NEW_PATTERN: m_new_pat = val;
      REG_NEW_LENGTH:  m_new_len = val[3:0];
      REG_SPARE_ROOM:  m_spare = val[11:0];
      default: ;
    endcase
  endtask

  task automatic add_byte(input logic [7:0] b, input logic last);
    text_item_t it;
    it = '{text: b, last: last};
    feed_q.push_back(it);
  endtask

  // Random length or room values with junk in the unused upper bits half of the time.
  function automatic logic [63:0] with_noise(input logic [63:0] v, input int keep);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(0, 1))
      return (junk << keep) | v;
    return v;
  endfunction

  task automatic random_setup();
    logic [63:0] pat;
    int pick;
    logic [3:0] len;
    logic [11:0] room;
    pat = {$urandom, $urandom};
    if ($urandom_range(0, 1))
      for (int k = 0; k < 8; k++)
        pat[8*k +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
    set_reg(REG_OLD_PATTERN, pat);
    pick = $urandom_range(0, 9);
    len = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd15 : (pick == 2) ? 4'd8 :
          4'($urandom_range(1, 4));
    set_reg(REG_OLD_LENGTH, with_noise(64'(len), 4));
    set_reg(REG_NEW_PATTERN, {$urandom, $urandom});
    pick = $urandom_range(0, 9);
    len = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd15 : (pick == 2) ? 4'd8 :
          4'($urandom_range(0, 6));
    set_reg(REG_NEW_LENGTH, with_noise(64'(len), 4));
    pick = $urandom_range(0, 5);
    room = (pick == 0) ? 12'd0 : (pick == 1) ? 12'd4095 : (pick == 2) ? 12'd1 :
           (pick == 3) ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 12));
    set_reg(REG_SPARE_ROOM, with_noise(64'(room), 12));
  endtask

  // Mostly whole pattern copies, some partial prefixes, the rest stray bytes.
  task automatic random_string(output int n_added);
    logic [7:0] txt[$];
    int plen, segs, r, cut;
    plen = (m_old_len > PATTERN_MAX) ? PATTERN_MAX : m_old_len;
    segs = $urandom_range(1, 6);
    for (int s = 0; s < segs; s++) begin
      r = $urandom_range(0, 99);
      if (r < 55 && plen > 0) begin
        for (int k = 0; k < plen; k++)
          txt.push_back(m_old_pat[8*k +: 8]);
      end else if (r < 75 && plen > 1) begin
        cut = $urandom_range(1, plen - 1);
        for (int k = 0; k < cut; k++)
          txt.push_back(m_old_pat[8*k +: 8]);
      end else if ($urandom_range(0, 1)) begin
        txt.push_back(8'($urandom_range(0, 255)));
      end else begin
        txt.push_back($urandom_range(0, 1) ? 8'h61 : 8'h62);
      end
    end
    foreach (txt[k])
      add_byte(txt[k], k == txt.size() - 1);
    n_added = txt.size();
  endtask

  initial begin : stimulus
    logic [63:0] pat8;
    int phase_items, got;
    int idle_plan [4][2];
    idle_plan = '{'{0, 0}, '{71, 0}, '{0, 71}, '{10, 10}};
    pat8 = 64'hF0E1D2C3B4A59687;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset config: one-byte pattern 00 replaced by nothing. Zero and FF text,
    // a dropped byte mid-string, and a last byte that leaves only an end marker.
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    wait_quiet();

    // "ab" -> "XYZ" with room for two growth steps.
    set_reg(REG_OLD_PATTERN, 64'h6261);
    set_reg(REG_OLD_LENGTH, 64'd2);
    set_reg(REG_NEW_PATTERN, 64'h5A5958);
    set_reg(REG_NEW_LENGTH, 64'd3);
    set_reg(REG_SPARE_ROOM, 64'd2);
    add_byte(8'h61, 1'b0);
    add_byte(8'h62, 1'b0);
    wait_quiet();
    // Mid-string: the new length waits for the next string, the new text is live.
    set_reg(REG_NEW_PATTERN, 64'h333231);
    set_reg(REG_NEW_LENGTH, 64'd0);
    add_byte(8'h61, 1'b0);
    add_byte(8'h62, 1'b0);
    add_byte(8'h61, 1'b0);   // room is gone here: replacing stops
    add_byte(8'h62, 1'b1);
    wait_quiet();

    // Old length zero: bytes pass straight through.
    set_reg(REG_OLD_LENGTH, 64'd0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h80, 1'b1);
    wait_quiet();

    // Oversized lengths clamp to eight; near-miss then full eight-byte match.
    set_reg(REG_OLD_PATTERN, pat8);
    set_reg(REG_OLD_LENGTH, 64'd15);
    set_reg(REG_NEW_PATTERN, 64'h0F1E2D3C4B5A6978);
    set_reg(REG_NEW_LENGTH, 64'd15);
    set_reg(REG_SPARE_ROOM, 64'd4095);
    for (int k = 0; k < 7; k++)
      add_byte(pat8[8*k +: 8], 1'b0);
    add_byte(8'h55, 1'b0);
    for (int k = 0; k < 8; k++)
      add_byte(pat8[8*k +: 8], k == 7);
    wait_quiet();

    // Random part: four idling phases, fresh settings every couple of strings.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph][0];
      recv_stall_pct = idle_plan[ph][1];
      phase_items = 0;
      while (phase_items < 50) begin
        wait_quiet();
        random_setup();
        repeat (2) begin
          random_string(got);
          phase_items += got;
        end
      end
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    if (due_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_q.size()));

    $display("covered %0d strings, %0d bytes in, %0d results out", n_strings, n_bytes_in,
             n_results);
    $display("%0d replacements made, %0d strings ran out of room", n_swaps, n_runouts);
    if (err_count == 0) begin
      $display("bounded_substring_replace_top_test: clean");
    end else begin
      $display("bounded_substring_replace_top_test: errors");
    end
    $finish;
  end

endmodule
